// ----- hw/rtl/co2_sensor_frame_checker_assert.svh -----
// Assertion macros for the CO2 sensor frame checker.
// Used by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef CO2_SENSOR_FRAME_CHECKER_ASSERT_SVH
`define CO2_SENSOR_FRAME_CHECKER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define CO2FC_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("co2 frame checker: implication violated");
// Next-cycle implication, checked at every rising edge outside reset.
`define CO2FC_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("co2 frame checker: next-cycle implication violated");
`else
`define CO2FC_ASSERT_IMP(name, clk, rst, ante, cons)
`define CO2FC_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/co2fc_pkg.sv -----
// Shared types, constants and functions of the CO2 sensor frame checker.
// No dependencies; used by co2fc_frame and co2_sensor_frame_checker.
package co2fc_pkg;

  // CRC-8 of each word: polynomial 0x31, start value 0xFF
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam logic [7:0] FAIL_LIMIT_RESET = 8'd12;

  // Input kind codes
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_BUS_ERR = 1'b1;

  // Byte positions inside the 9-byte frame
  localparam int unsigned POS_W = 4;
  localparam logic [POS_W-1:0] POS_CO2_MSB = 4'd0;
  localparam logic [POS_W-1:0] POS_CO2_LSB = 4'd1;
  localparam logic [POS_W-1:0] POS_CO2_CRC = 4'd2;
  localparam logic [POS_W-1:0] POS_T_MSB   = 4'd3;
  localparam logic [POS_W-1:0] POS_T_LSB   = 4'd4;
  localparam logic [POS_W-1:0] POS_T_CRC   = 4'd5;
  localparam logic [POS_W-1:0] POS_H_MSB   = 4'd6;
  localparam logic [POS_W-1:0] POS_H_LSB   = 4'd7;
  localparam logic [POS_W-1:0] POS_H_CRC   = 4'd8;

  // Scale factors: full scale word 65535 maps to these spans
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [13:0] HUM_SPAN    = 14'd10000;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [16:0] WORD_FULL   = 17'd65535;

  // Payload widths
  localparam int unsigned CO2_W  = 16;
  localparam int unsigned TEMP_W = 15;
  localparam int unsigned HUM_W  = 14;
  localparam int unsigned TPROD_W = 31;
  localparam int unsigned HPROD_W = 30;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_CRC_ERR = 2'd1,
    STATUS_BUS_ERR = 2'd2,
    STATUS_NO_DATA = 2'd3
  } status_t;

  // Result of one input item, as handed from the frame logic to the output register
  typedef struct packed {
    logic                     valid;
    status_t                  status;
    logic [CO2_W-1:0]         co2_ppm;
    logic signed [TEMP_W-1:0] temperature_centi;
    logic [HUM_W-1:0]         humidity_centi;
    logic                     restart_request;
  } frame_result_t;

  // One CRC-8 update over a whole byte, MSB first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // floor(p / 65535) for p below 2^31: p = q*65535 + (q + r), q + r < 2*65535
  function automatic logic [14:0] div_by_full(input logic [TPROD_W-1:0] p);
    logic [14:0] q;
    logic [16:0] s;
    q = p[30:16];
    s = {2'b00, q} + {1'b0, p[15:0]};
    return q + ((s >= WORD_FULL) ? 15'd1 : 15'd0);
  endfunction

endpackage

// ----- hw/rtl/co2fc_frame.sv -----
// Frame assembly, CRC check, value scaling and failure supervision.
// Depends on co2fc_pkg; instantiated by co2_sensor_frame_checker.
module co2fc_frame (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic                    kind,
  input  logic [7:0]              byte_value,
  input  logic [7:0]              fail_limit,
  output co2fc_pkg::frame_result_t result
);

  logic [co2fc_pkg::POS_W-1:0]   byte_position, byte_position_next;
  logic [7:0]                    crc_accumulator, crc_accumulator_next;
  logic [7:0]                    high_byte_hold, high_byte_hold_next;
  logic [co2fc_pkg::CO2_W-1:0]   co2_word, co2_word_next;
  logic [co2fc_pkg::TPROD_W-1:0] temp_product, temp_product_next;
  logic [co2fc_pkg::HPROD_W-1:0] hum_product, hum_product_next;
  logic                          frame_crc_good, frame_crc_good_next;
  logic [7:0]                    failure_count, failure_count_next;

  logic [15:0] word;
  logic [7:0]  crc_updated;
  logic        crc_match;
  logic        frame_good;
  logic [7:0]  fail_bumped;
  logic        fail_hit;
  logic [14:0] temp_scaled;
  logic [14:0] hum_scaled;

  assign word        = {high_byte_hold, byte_value};
  assign crc_updated = co2fc_pkg::crc8_step(crc_accumulator, byte_value);
  assign crc_match   = (crc_accumulator == byte_value);
  assign frame_good  = frame_crc_good & crc_match;
  assign fail_bumped = failure_count + 8'd1;
  assign fail_hit    = (fail_bumped >= fail_limit);
  assign temp_scaled = co2fc_pkg::div_by_full(temp_product);
  assign hum_scaled  = co2fc_pkg::div_by_full({1'b0, hum_product});

  // Advance the frame state and build the result of one item
  always_comb begin
    byte_position_next   = byte_position;
    crc_accumulator_next = crc_accumulator;
    high_byte_hold_next  = high_byte_hold;
    co2_word_next        = co2_word;
    temp_product_next    = temp_product;
    hum_product_next     = hum_product;
    frame_crc_good_next  = frame_crc_good;
    failure_count_next   = failure_count;
    result               = '0;

    if (step) begin
      if (kind == co2fc_pkg::KIND_BUS_ERR) begin
        // Drop the partial frame and count the failure
        byte_position_next   = co2fc_pkg::POS_CO2_MSB;
        crc_accumulator_next = co2fc_pkg::CRC_INIT;
        high_byte_hold_next  = '0;
        frame_crc_good_next  = 1'b1;
        result.valid         = 1'b1;
        result.status        = co2fc_pkg::STATUS_BUS_ERR;
        result.restart_request = fail_hit;
        failure_count_next   = fail_hit ? 8'd0 : fail_bumped;
      end else begin
        case (byte_position) inside
          co2fc_pkg::POS_CO2_MSB, co2fc_pkg::POS_T_MSB, co2fc_pkg::POS_H_MSB: begin
            high_byte_hold_next  = byte_value;
            crc_accumulator_next = crc_updated;
          end
          co2fc_pkg::POS_CO2_LSB: begin
            co2_word_next        = word;
            crc_accumulator_next = crc_updated;
          end
          co2fc_pkg::POS_T_LSB: begin
            temp_product_next    = co2fc_pkg::TPROD_W'(word) *
                                   co2fc_pkg::TPROD_W'(co2fc_pkg::TEMP_SPAN);
            crc_accumulator_next = crc_updated;
          end
          co2fc_pkg::POS_H_LSB: begin
            hum_product_next     = co2fc_pkg::HPROD_W'(word) *
                                   co2fc_pkg::HPROD_W'(co2fc_pkg::HUM_SPAN);
            crc_accumulator_next = crc_updated;
          end
          default: begin
            // CRC byte: compare and restart the accumulator for the next word
            if (!crc_match) begin
              frame_crc_good_next = 1'b0;
            end
            crc_accumulator_next = co2fc_pkg::CRC_INIT;
          end
        endcase

        if (byte_position == co2fc_pkg::POS_H_CRC) begin
          // Frame complete: report and restart
          result.valid         = 1'b1;
          byte_position_next   = co2fc_pkg::POS_CO2_MSB;
          crc_accumulator_next = co2fc_pkg::CRC_INIT;
          high_byte_hold_next  = '0;
          frame_crc_good_next  = 1'b1;
          if (!frame_good) begin
            result.status          = co2fc_pkg::STATUS_CRC_ERR;
            result.restart_request = fail_hit;
            failure_count_next     = fail_hit ? 8'd0 : fail_bumped;
          end else if (co2_word == '0) begin
            result.status = co2fc_pkg::STATUS_NO_DATA;
          end else begin
            result.status            = co2fc_pkg::STATUS_OK;
            result.co2_ppm           = co2_word;
            result.temperature_centi = $signed(temp_scaled - co2fc_pkg::TEMP_OFFSET);
            result.humidity_centi    = hum_scaled[co2fc_pkg::HUM_W-1:0];
            failure_count_next       = '0;
          end
        end else begin
          byte_position_next = byte_position + 4'd1;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= co2fc_pkg::POS_CO2_MSB;
      crc_accumulator <= co2fc_pkg::CRC_INIT;
      high_byte_hold  <= '0;
      frame_crc_good  <= 1'b1;
      failure_count   <= '0;
    end else begin
      byte_position   <= byte_position_next;
      crc_accumulator <= crc_accumulator_next;
      high_byte_hold  <= high_byte_hold_next;
      frame_crc_good  <= frame_crc_good_next;
      failure_count   <= failure_count_next;
    end
  end

  // Word payload, always written before it is read within a frame
  always_ff @(posedge clk) begin
    co2_word     <= co2_word_next;
    temp_product <= temp_product_next;
    hum_product  <= hum_product_next;
  end

endmodule

// ----- hw/rtl/co2_sensor_frame_checker.sv -----
// Top level of the CO2 sensor frame checker: stream handshake, input and result registers.
// Depends on co2fc_pkg, co2fc_frame and co2_sensor_frame_checker_assert.svh.
//
// Channel   Dir  Fields (low bit up)                                        Accepted when
// s_        in   tdata: byte_value[7:0]; tuser: kind[0]                     s_tvalid & s_tready
// m_        out  tdata: co2_ppm, temperature_centi, humidity_centi,         m_tvalid & m_tready
//                restart_request, 2 zero bits; tuser: status[1:0]
// cfg_      in   cfg_wdata: fail_limit[7:0]                                 cfg_we
//
// One item per cycle sustained while the result register holds no untaken result; a result
// passes through the input register, then the frame logic into the result register.
// The result register stalls the input register only while it holds an untaken result.
// Reset (rst, synchronous) empties both registers, starts a new frame, clears the
// failure count and sets fail_limit to 12.
`include "co2_sensor_frame_checker_assert.svh"

module co2_sensor_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_value
  input  logic [0:0]  s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [15:0] co2_ppm, [30:16] temperature_centi,
                                 // [44:31] humidity_centi, [45] restart_request, [47:46] 0
  output logic [1:0]  m_tuser,   // [1:0] status
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  logic                     in_valid;
  logic                     in_kind;
  logic [7:0]               in_byte;
  logic [7:0]               fail_limit;
  logic                     advance;
  co2fc_pkg::frame_result_t result;

  assign advance  = in_valid & (~m_tvalid | m_tready);
  assign s_tready = ~in_valid | advance;

  // Hold the failure limit
  always_ff @(posedge clk) begin
    if (rst) begin
      fail_limit <= co2fc_pkg::FAIL_LIMIT_RESET;
    end else if (cfg_we) begin
      fail_limit <= cfg_wdata;
    end
  end

  // Input register: load on each transaction, drain when the frame logic takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind <= s_tuser[0];
      in_byte <= s_tdata;
    end
  end

  co2fc_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .kind       (in_kind),
    .byte_value (in_byte),
    .fail_limit (fail_limit),
    .result     (result)
  );

  // Result register: drop on a taken transaction, load a new result
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && result.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      m_tdata <= {2'b00, result.restart_request, result.humidity_centi,
                  result.temperature_centi, result.co2_ppm};
      m_tuser <= result.status;
    end
  end

  // Checks
  `CO2FC_ASSERT_IMP(a_ready_when_empty, clk, rst, !m_tvalid, s_tready)
  `CO2FC_ASSERT_IMP(a_stall_only_on_full, clk, rst, in_valid && !advance,
                    m_tvalid && !m_tready)
  `CO2FC_ASSERT_NEXT(a_result_loaded, clk, rst, advance && result.valid, m_tvalid)
  `CO2FC_ASSERT_IMP(a_fields_zero_unless_ok, clk, rst,
                    m_tvalid && (m_tuser != co2fc_pkg::STATUS_OK), m_tdata[44:0] == '0)
  `CO2FC_ASSERT_IMP(a_no_restart_on_good, clk, rst,
                    m_tvalid && ((m_tuser == co2fc_pkg::STATUS_OK) ||
                                 (m_tuser == co2fc_pkg::STATUS_NO_DATA)), !m_tdata[45])

endmodule
